[hdl/sid_pkg.sv]
// Package for the SIC/XE instruction decoder: codes, queue entry and result
// types, the format-2 opcode table. No dependencies.
`default_nettype none

package sid_pkg;

  localparam int unsigned SID_QUEUE_DEPTH = 2;
  localparam int unsigned ADDR_W = 20;

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_START = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    FMT_2 = 2'd0,
    FMT_3 = 2'd1,
    FMT_4 = 2'd2
  } fmt_e;

  typedef enum logic [1:0] {
    TM_ABS  = 2'd0,
    TM_BASE = 2'd1,
    TM_PC   = 2'd2,
    TM_NONE = 2'd3
  } tmode_e;

  // Six-bit opcodes (first byte >> 2)
  localparam logic [5:0] OPC_LDB = 6'h1A;
  localparam int unsigned NUM_FMT2 = 11;
  localparam logic [5:0] FMT2_OPS [NUM_FMT2] = '{
    6'h24, 6'h2D, 6'h28, 6'h27, 6'h26, 6'h2B,
    6'h29, 6'h2A, 6'h25, 6'h2C, 6'h2E
  };

  // Register 7 and numbers above REG_MAX are invalid in a format-2 instruction
  localparam logic [3:0] REG_BAD = 4'd7;
  localparam logic [3:0] REG_MAX = 4'd9;

  typedef struct packed {
    logic [ADDR_W-1:0] instr_address;
    logic [31:0]       word;
    fmt_e              fmt;
  } raw_instr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] instr_address;
    logic [5:0]        opcode;
    fmt_e              format_code;
    logic              flag_n;
    logic              flag_i;
    logic              flag_x;
    tmode_e            target_mode;
    logic [ADDR_W-1:0] target_address;
    logic [3:0]        register_one;
    logic [31:0]       object_word;
    logic              status;
  } result_t;

  // Handshake between front and queue
  typedef struct packed {
    logic       valid;
    raw_instr_t item;
  } push_t;

  function automatic logic is_format2(input logic [5:0] op);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_FMT2; k++) begin
      if (FMT2_OPS[k] == op) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

[hdl/sid_in_if.sv]
// Input channel of the decoder: valid/ready plus one byte or record start.
// Uses no package.
`default_nettype none

interface sid_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  byte_value;
  logic [19:0] start_address;

  modport source (output valid, kind, byte_value, start_address, input ready);
  modport sink   (input valid, kind, byte_value, start_address, output ready);
endinterface

`default_nettype wire

[hdl/sid_out_if.sv]
// Output channel of the decoder: valid/ready plus one decoded instruction.
// Uses no package.
`default_nettype none

interface sid_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] instr_address;
  logic [5:0]  opcode;
  logic [1:0]  format_code;
  logic        flag_n;
  logic        flag_i;
  logic        flag_x;
  logic [1:0]  target_mode;
  logic [19:0] target_address;
  logic [3:0]  register_one;
  logic [31:0] object_word;
  logic        status;

  modport source (output valid, instr_address, opcode, format_code, flag_n, flag_i,
                  flag_x, target_mode, target_address, register_one, object_word,
                  status, input ready);
  modport sink   (input valid, instr_address, opcode, format_code, flag_n, flag_i,
                  flag_x, target_mode, target_address, register_one, object_word,
                  status, output ready);
endinterface

`default_nettype wire

[hdl/sid_front.sv]
// Front end: assembles object code bytes into instructions, keeps the
// location counter. Depends on sid_pkg and sid_in_if.
`default_nettype none

module sid_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  sid_in_if.sink          in_i,
  input  logic            q_ready_i,
  output sid_pkg::push_t  push_o
);
  import sid_pkg::*;

  logic [ADDR_W-1:0] lc_q, lc_d;
  logic [31:0]       buf_q, buf_d;
  logic [2:0]        held_q, held_d;
  logic [2:0]        exp_q, exp_d;
  logic [31:0]       buf_n;
  logic [2:0]        held_n, exp_n;
  logic              accept, done;

  assign in_i.ready = q_ready_i;
  assign accept     = in_i.valid && q_ready_i;

  always_comb begin
    buf_n  = {buf_q[23:0], in_i.byte_value};
    held_n = held_q + 3'd1;
    exp_n  = exp_q;
    if (held_q == 3'd0) begin
      exp_n = is_format2(in_i.byte_value[7:2]) ? 3'd2 : 3'd0;
    end else if (held_q == 3'd1 && exp_q == 3'd0) begin
      exp_n = in_i.byte_value[4] ? 3'd4 : 3'd3;
    end
    done = (kind_e'(in_i.kind) == KIND_BYTE) && (exp_n != 3'd0) && (held_n == exp_n);

    lc_d   = lc_q;
    buf_d  = buf_q;
    held_d = held_q;
    exp_d  = exp_q;
    if (accept) begin
      if (kind_e'(in_i.kind) == KIND_START) begin
        // drop any partial instruction
        lc_d   = in_i.start_address;
        buf_d  = '0;
        held_d = '0;
        exp_d  = '0;
      end else if (done) begin
        lc_d   = lc_q + ADDR_W'(exp_n);
        buf_d  = '0;
        held_d = '0;
        exp_d  = '0;
      end else begin
        buf_d  = buf_n;
        held_d = held_n;
        exp_d  = exp_n;
      end
    end

    push_o.valid              = accept && done;
    push_o.item.instr_address = lc_q;
    push_o.item.word          = buf_n;
    push_o.item.fmt           = fmt_e'(exp_n[1:0] - 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q   <= '0;
      buf_q  <= '0;
      held_q <= '0;
      exp_q  <= '0;
    end else begin
      lc_q   <= lc_d;
      buf_q  <= buf_d;
      held_q <= held_d;
      exp_q  <= exp_d;
    end
  end

endmodule

`default_nettype wire

[hdl/sid_queue.sv]
// Short queue of assembled instructions between front and back end.
// Depends on sid_pkg.
`default_nettype none

module sid_queue #(
  parameter int unsigned Depth = sid_pkg::SID_QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sid_pkg::push_t      push_i,
  output logic                ready_o,
  output logic                valid_o,
  output sid_pkg::raw_instr_t head_o,
  input  logic                pop_i
);
  import sid_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  raw_instr_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i.valid && ready_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_d  = do_push ? bump(wr_q) : wr_q;
    rd_d  = do_pop ? bump(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[hdl/sid_back.sv]
// Back end: decodes fields and target address of each queued instruction,
// keeps the base register, holds the result register.
// Depends on sid_pkg and sid_out_if.
`default_nettype none

module sid_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  sid_pkg::raw_instr_t head_i,
  output logic                pop_o,
  sid_out_if.source           out_o
);
  import sid_pkg::*;

  logic [ADDR_W-1:0] base_q, base_d;
  logic              ovld_q, ovld_d;
  result_t           res_q, res_d;
  logic [7:0]        first, second;
  logic [11:0]       disp;
  logic [ADDR_W-1:0] next_loc;

  assign pop_o = valid_i && (!ovld_q || out_o.ready);

  always_comb begin
    unique case (head_i.fmt)
      FMT_2:   begin first = head_i.word[15:8];  second = head_i.word[7:0];   end
      FMT_4:   begin first = head_i.word[31:24]; second = head_i.word[23:16]; end
      default: begin first = head_i.word[23:16]; second = head_i.word[15:8];  end
    endcase
    disp     = head_i.word[11:0];
    next_loc = head_i.instr_address + ADDR_W'(head_i.fmt) + ADDR_W'(2);

    res_d                = '0;
    res_d.instr_address  = head_i.instr_address;
    res_d.opcode         = first[7:2];
    res_d.format_code    = head_i.fmt;
    res_d.object_word    = head_i.word;
    res_d.target_mode    = TM_NONE;
    base_d               = base_q;

    if (head_i.fmt == FMT_2) begin
      res_d.register_one = second[7:4];
      res_d.status       = (second[7:4] == REG_BAD) || (second[7:4] > REG_MAX);
    end else begin
      res_d.flag_n = first[1];
      res_d.flag_i = first[0];
      res_d.flag_x = second[7];
      if (head_i.fmt == FMT_4) begin
        res_d.target_mode    = TM_ABS;
        res_d.target_address = head_i.word[ADDR_W-1:0];
        if (pop_o && first[7:2] == OPC_LDB) base_d = head_i.word[ADDR_W-1:0];
      end else begin
        priority if (second[6] == second[5]) begin
          res_d.target_mode    = TM_ABS;
          res_d.target_address = ADDR_W'(disp);
        end else if (second[6]) begin
          res_d.target_mode    = TM_BASE;
          res_d.target_address = base_q + ADDR_W'(disp);
        end else begin
          res_d.target_mode    = TM_PC;
          res_d.target_address = next_loc + {{(ADDR_W-12){disp[11]}}, disp};
        end
      end
    end

    // advance result register when it is free or its word is taken
    ovld_d = pop_o ? 1'b1 : (ovld_q && !out_o.ready);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
      base_q <= '0;
    end else begin
      ovld_q <= ovld_d;
      base_q <= base_d;
    end
  end

  assign out_o.valid          = ovld_q;
  assign out_o.instr_address  = res_q.instr_address;
  assign out_o.opcode         = res_q.opcode;
  assign out_o.format_code    = res_q.format_code;
  assign out_o.flag_n         = res_q.flag_n;
  assign out_o.flag_i         = res_q.flag_i;
  assign out_o.flag_x         = res_q.flag_x;
  assign out_o.target_mode    = res_q.target_mode;
  assign out_o.target_address = res_q.target_address;
  assign out_o.register_one   = res_q.register_one;
  assign out_o.object_word    = res_q.object_word;
  assign out_o.status         = res_q.status;

endmodule

`default_nettype wire

[hdl/sic_xe_instruction_decoder.sv]
// SIC/XE instruction decoder: one byte or record start accepted per cycle
// while the queue has room. Once an instruction's last byte is accepted, it
// is queued; its result is valid once the back end loads its result register.
// Throughput: one byte per cycle while the queue has room; it drains one
// instruction per cycle into the result register while that is free or taken.
// Reset clears location counter, base register, partial instruction and queue.
`default_nettype none

module sic_xe_instruction_decoder #(
  parameter int unsigned QueueDepth = sid_pkg::SID_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sid_in_if.sink    in_i,
  sid_out_if.source out_o
);
  import sid_pkg::*;

  push_t      push;
  logic       q_ready, q_valid, q_pop;
  raw_instr_t q_head;

  sid_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push)
  );

  sid_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  sid_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .head_i  (q_head),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
